// ===== rtl/core/dluc_pkg.sv =====
// shared types, codes and constants of the digit line identifier capture block
package dluc_pkg;

   // input item kinds
   localparam logic [1:0] OP_CHAR = 2'd0;
   localparam logic [1:0] OP_EOL  = 2'd1;
   localparam logic [1:0] OP_READ = 2'd2;

   // field widths
   localparam int CHAR_W     = 8;
   localparam int BYTE_W     = 8;
   localparam int BYTE_IDX_W = 4;
   localparam int LEN_W      = 4;

   // default store depth
   localparam int UID_BYTES_MAX_DEF = 10;

   // ascii digit bounds
   localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;

   // identifier lengths that are taken
   localparam int LEN_SHORT  = 4;
   localparam int LEN_DOUBLE = 7;
   localparam int LEN_TRIPLE = 10;

   // commands from controller to datapath
   typedef struct packed {
      logic take_char;
      logic take_eol;
      logic take_read;
      logic emit_byte;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic read_go;
      logic read_last;
   } stat_type;

   // one result item
   typedef struct packed {
      logic                  line_accepted;
      logic [BYTE_W-1:0]     uid_byte;
      logic [BYTE_IDX_W-1:0] byte_index;
      logic [LEN_W-1:0]      uid_length;
      logic                  status;
      logic                  uid_ready;
      logic                  last_of_run;
   } rsp_type;

endpackage

// ===== rtl/core/dluc_ctrl.sv =====
// controller: handshakes, read walk sequencing and result valid flag
module dluc_ctrl
   import dluc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [1:0] req_op,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  stat_type   stat,
   output cmd_type    cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_READ = 1'b1;

   logic state_ff, state_in;
   logic out_valid_ff, out_valid_in;
   logic slot_free;
   logic req_acc;
   logic out_load;

   // result register can take a new item
   assign slot_free  = !out_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && slot_free;
   assign req_acc    = req_tvalid && req_tready;
   assign rsp_tvalid = out_valid_ff;

   // commands to the datapath
   always_comb begin
      cmd.take_char = req_acc && (req_op == OP_CHAR);
      cmd.take_eol  = req_acc && (req_op == OP_EOL);
      cmd.take_read = req_acc && (req_op == OP_READ);
      cmd.emit_byte = (state_ff == ST_READ) && slot_free;
   end

   // result register loads
   assign out_load = cmd.take_eol || (cmd.take_read && !stat.read_go) || cmd.emit_byte;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.take_read && stat.read_go) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            if (cmd.emit_byte && stat.read_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

// ===== rtl/core/dluc_dpath.sv =====
// datapath: digit pairing, scratch and held stores, result register
module dluc_dpath
   import dluc_pkg::*;
#(
   parameter int UID_BYTES_MAX = UID_BYTES_MAX_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   input  logic [CHAR_W-1:0] req_char,
   output stat_type          stat,
   output rsp_type           rsp
);

   localparam int CNT_W = $clog2(UID_BYTES_MAX + 1);
   localparam int IDX_W = $clog2(UID_BYTES_MAX);

   logic [3:0]         high_digit_ff, high_digit_in;
   logic               half_pair_ff, half_pair_in;
   logic               line_bad_ff, line_bad_in;
   logic [CNT_W-1:0]   scratch_count_ff, scratch_count_in;
   logic [BYTE_W-1:0]  scratch_ff [UID_BYTES_MAX];
   logic [BYTE_W-1:0]  held_ff [UID_BYTES_MAX];
   logic [LEN_W-1:0]   held_length_ff, held_length_in;
   logic               held_ready_ff, held_ready_in;
   logic               last_status_ff, last_status_in;
   logic [BYTE_IDX_W-1:0] rd_idx_ff, rd_idx_in;
   rsp_type            out_ff, out_in;
   logic               out_load;

   logic               is_digit;
   logic [CHAR_W-1:0]  char_off;
   logic [3:0]         digit;
   logic               count_full;
   logic               byte_wr;
   logic               eol_ok;

   // character decode
   assign is_digit   = (req_char >= CHAR_ZERO) && (req_char <= CHAR_NINE);
   assign char_off   = req_char - CHAR_ZERO;
   assign digit      = char_off[3:0];
   assign count_full = (scratch_count_ff == CNT_W'(UID_BYTES_MAX));
   assign byte_wr    = cmd.take_char && is_digit && half_pair_ff && !count_full;

   // line check at end of line
   assign eol_ok = !line_bad_ff && !half_pair_ff &&
                   ((scratch_count_ff == CNT_W'(LEN_SHORT)) ||
                    (scratch_count_ff == CNT_W'(LEN_DOUBLE)) ||
                    (scratch_count_ff == CNT_W'(LEN_TRIPLE)));

   // status for the sequencer
   assign stat.read_go   = held_ready_ff && (held_length_ff != '0);
   assign stat.read_last = ({1'b0, rd_idx_ff} + 5'd1) == {1'b0, held_length_ff};

   // next state of line, holding store control and result register
   always_comb begin
      high_digit_in    = high_digit_ff;
      half_pair_in     = half_pair_ff;
      line_bad_in      = line_bad_ff;
      scratch_count_in = scratch_count_ff;
      held_length_in   = held_length_ff;
      held_ready_in    = held_ready_ff;
      last_status_in   = last_status_ff;
      rd_idx_in        = rd_idx_ff;
      out_in           = out_ff;
      out_load         = 1'b0;

      if (cmd.take_char) begin
         if (!is_digit) begin
            line_bad_in = 1'b1;
         end else if (!half_pair_ff) begin
            high_digit_in = digit;
            half_pair_in  = 1'b1;
         end else begin
            if (!count_full) begin
               scratch_count_in = scratch_count_ff + CNT_W'(1);
            end else begin
               line_bad_in = 1'b1;
            end
            half_pair_in = 1'b0;
         end
      end

      if (cmd.take_eol) begin
         out_load             = 1'b1;
         out_in               = '0;
         out_in.last_of_run   = 1'b1;
         out_in.line_accepted = eol_ok;
         if (eol_ok) begin
            held_length_in    = LEN_W'(scratch_count_ff);
            held_ready_in     = 1'b1;
            last_status_in    = 1'b0;
            out_in.uid_length = LEN_W'(scratch_count_ff);
            out_in.status     = 1'b0;
            out_in.uid_ready  = 1'b1;
         end else begin
            out_in.uid_length = held_length_ff;
            out_in.status     = last_status_ff;
            out_in.uid_ready  = held_ready_ff;
         end
         high_digit_in    = '0;
         half_pair_in     = 1'b0;
         line_bad_in      = 1'b0;
         scratch_count_in = '0;
      end

      if (cmd.take_read) begin
         if (held_ready_ff) begin
            held_ready_in  = 1'b0;
            last_status_in = 1'b0;
            rd_idx_in      = '0;
         end
         if (!stat.read_go) begin
            // no card, or an empty identifier
            out_load           = 1'b1;
            out_in             = '0;
            out_in.status      = !held_ready_ff;
            out_in.last_of_run = 1'b1;
         end
      end

      if (cmd.emit_byte) begin
         out_load           = 1'b1;
         out_in             = '0;
         out_in.uid_byte    = held_ff[rd_idx_ff[IDX_W-1:0]];
         out_in.byte_index  = rd_idx_ff;
         out_in.uid_length  = held_length_ff;
         out_in.last_of_run = stat.read_last;
         rd_idx_in          = rd_idx_ff + BYTE_IDX_W'(1);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         high_digit_ff    <= '0;
         half_pair_ff     <= 1'b0;
         line_bad_ff      <= 1'b0;
         scratch_count_ff <= '0;
         held_length_ff   <= '0;
         held_ready_ff    <= 1'b0;
         last_status_ff   <= 1'b1;
         rd_idx_ff        <= '0;
      end else begin
         high_digit_ff    <= high_digit_in;
         half_pair_ff     <= half_pair_in;
         line_bad_ff      <= line_bad_in;
         scratch_count_ff <= scratch_count_in;
         held_length_ff   <= held_length_in;
         held_ready_ff    <= held_ready_in;
         last_status_ff   <= last_status_in;
         rd_idx_ff        <= rd_idx_in;
      end
   end

   // scratch byte write
   always_ff @(posedge clock) begin
      if (byte_wr) begin
         scratch_ff[scratch_count_ff[IDX_W-1:0]] <= {high_digit_ff, digit};
      end
   end

   // commit of an accepted line into the holding store
   always_ff @(posedge clock) begin
      if (cmd.take_eol && eol_ok) begin
         held_ff <= scratch_ff;
      end
   end

   // result payload register
   always_ff @(posedge clock) begin
      if (out_load) begin
         out_ff <= out_in;
      end
   end

   assign rsp = out_ff;

endmodule

// ===== rtl/core/digit_line_uid_capture_core.sv =====
// top level of the digit line identifier capture block
// Use: feed the characters of one text line on the req channel with tuser set to
// the character kind, then an end-of-line item; it answers with one item telling
// whether the line was committed as an identifier. A read item (tuser read) gives
// the held identifier bytes on the rsp channel, low index first, tlast on the last,
// or one no-card item (tuser high) when nothing is waiting.
// An end-of-line or no-card result is registered and valid the cycle after acceptance.
// Characters and end-of-line items are taken one per cycle while req_tready is high.
// A read takes its item, then gives its bytes one per cycle while the receiver takes
// them, through the single read port of the holding store; the next item is taken with the last byte.
// Reset clears the line in progress and drops any held identifier (status no card).
// When the receiver stalls, the result register holds its item and req_tready
// falls until the item is taken; a read walk pauses on the same condition.
module digit_line_uid_capture_core
   import dluc_pkg::*;
#(
   parameter int UID_BYTES_MAX = UID_BYTES_MAX_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // char_code[7:0]
   input  logic [1:0]  req_tuser,   // op[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // line_accepted[0], uid_byte[8:1], byte_index[12:9],
                                    // uid_length[16:13], uid_ready[17], zero[23:18]
   output logic        rsp_tuser,   // status[0]
   output logic        rsp_tlast
);

   cmd_type  cmd;
   stat_type stat;
   rsp_type  rsp;

   dluc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   dluc_dpath #(
      .UID_BYTES_MAX (UID_BYTES_MAX)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_char (req_tdata),
      .stat     (stat),
      .rsp      (rsp)
   );

   // result packing
   assign rsp_tdata = {6'd0, rsp.uid_ready, rsp.uid_length, rsp.byte_index,
                       rsp.uid_byte, rsp.line_accepted};
   assign rsp_tuser = rsp.status;
   assign rsp_tlast = rsp.last_of_run;

   // a stalled result blocks new items
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("item accepted while result stalled");

   // a no-card result stands alone
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tlast && rsp_tdata == 24'd0))
      else $error("no-card result malformed");

   // a line character never raises a result
   assert property (@(posedge clock) disable iff (reset)
      (cmd.take_char && !rsp_tvalid && !u_ctrl.state_ff) |=> !rsp_tvalid)
      else $error("result from a line character");

endmodule

// ===== dv/testbench.sv =====
// self-checking testbench of the digit line identifier capture block
`timescale 1ns / 100ps

module testbench;
   import dluc_pkg::*;

   // store depth and an opcode the block must ignore
   localparam int         ID_MAX         = UID_BYTES_MAX_DEF;
   localparam logic [1:0] OP_IGNORED     = 2'd3;
   localparam int         RANDOM_ITEMS   = 400;
   localparam int         LONG_HOLD      = 120;
   localparam int         WATCHDOG_LIMIT = 1000;
   localparam int         DRAIN_CYCLES   = 20;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;   // char_code[7:0]
   logic [1:0]  req_tuser = '0;   // op[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;        // line_accepted[0], uid_byte[8:1], byte_index[12:9],
                                  // uid_length[16:13], uid_ready[17], zero[23:18]
   logic        rsp_tuser;        // status[0]
   logic        rsp_tlast;

   // shared control between stimulus, receiver and checker
   bit          idle_on = 1'b1;
   bit          hold_request = 1'b0;
   int          error_count = 0;
   int          items_sent = 0;
   int          lines_committed = 0;
   int          lines_rejected = 0;
   int          id_bytes_read = 0;
   int          no_card_reads = 0;
   int          quiet_cycles = 0;
   rsp_type     pending_answers[$];

   // predictor state of the capture
   logic [3:0]  pair_high = '0;
   logic        pair_open = 1'b0;
   logic        line_rejected = 1'b0;
   logic [3:0]  bytes_formed = '0;
   logic [7:0]  formed_bytes [ID_MAX];
   logic [7:0]  held_id [ID_MAX];
   logic [3:0]  held_len = '0;
   logic        id_waiting = 1'b0;
   logic        card_status = 1'b1;

   digit_line_uid_capture_core #(
      .UID_BYTES_MAX(ID_MAX)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // work out the results of one accepted item
   task automatic predict_capture(input logic [1:0] op, input logic [7:0] ch);
      rsp_type    answer;
      logic [7:0] offset;
      logic [3:0] digit;
      logic       take;
      int         i;
      answer = '0;
      case (op)
         OP_CHAR: begin
            if (ch < CHAR_ZERO || ch > CHAR_NINE) begin
               line_rejected = 1'b1;
            end else begin
               offset = ch - CHAR_ZERO;
               digit  = offset[3:0];
               if (!pair_open) begin
                  pair_high = digit;
                  pair_open = 1'b1;
               end else begin
                  // a byte past the store depth spoils the line
                  if (bytes_formed < ID_MAX) begin
                     formed_bytes[bytes_formed] = {pair_high, digit};
                     bytes_formed = bytes_formed + 4'd1;
                  end else begin
                     line_rejected = 1'b1;
                  end
                  pair_open = 1'b0;
               end
            end
         end
         OP_EOL: begin
            take = !line_rejected && !pair_open &&
                   (bytes_formed == LEN_SHORT || bytes_formed == LEN_DOUBLE ||
                    bytes_formed == LEN_TRIPLE);
            if (take) begin
               for (i = 0; i < ID_MAX; i++)
                  held_id[i] = (i < bytes_formed) ? formed_bytes[i] : 8'h00;
               held_len    = bytes_formed;
               id_waiting  = 1'b1;
               card_status = 1'b0;
               lines_committed++;
            end else begin
               lines_rejected++;
            end
            pair_high     = '0;
            pair_open     = 1'b0;
            line_rejected = 1'b0;
            bytes_formed  = '0;
            answer.line_accepted = take;
            answer.uid_length    = held_len;
            answer.status        = card_status;
            answer.uid_ready     = id_waiting;
            answer.last_of_run   = 1'b1;
            pending_answers.push_back(answer);
         end
         OP_READ: begin
            if (!id_waiting) begin
               // no card waiting
               answer.status      = 1'b1;
               answer.last_of_run = 1'b1;
               pending_answers.push_back(answer);
               no_card_reads++;
            end else begin
               id_waiting  = 1'b0;
               card_status = 1'b0;
               for (i = 0; i < held_len; i++) begin
                  answer.uid_byte    = held_id[i];
                  answer.byte_index  = 4'(i);
                  answer.uid_length  = held_len;
                  answer.last_of_run = (i + 1 == held_len);
                  pending_answers.push_back(answer);
                  id_bytes_read++;
               end
            end
         end
         default: ;
      endcase
   endtask

   // offer one item, wait until it is taken, then predict
   task automatic send_item(input logic [1:0] op, input logic [7:0] ch);
      int gap;
      gap = idle_on ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      req_tuser  <= op;
      do @(posedge clock); while (!req_tready);
      predict_capture(op, ch);
      if (op != OP_IGNORED)
         items_sent++;
   endtask

   // stop offering and wait for every expected item
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] pick_digit();
      return CHAR_ZERO + 8'($urandom_range(0, 9));
   endfunction

   // non-digit, leaning on the bounds around the digit range
   function automatic logic [7:0] pick_non_digit();
      logic [7:0] c;
      case ($urandom_range(0, 4))
         0: c = 8'h00;
         1: c = 8'hFF;
         2: c = CHAR_ZERO - 8'd1;
         3: c = CHAR_NINE + 8'd1;
         default: begin
            c = 8'($urandom_range(0, 255));
            while (c >= CHAR_ZERO && c <= CHAR_NINE) c = 8'($urandom_range(0, 255));
         end
      endcase
      return c;
   endfunction

   function automatic int pick_good_length();
      case ($urandom_range(0, 2))
         0:       return LEN_SHORT;
         1:       return LEN_DOUBLE;
         default: return LEN_TRIPLE;
      endcase
   endfunction

   // one line of digits closed by an end of line, with optional faults mixed in
   task automatic send_digit_line(input int n_bytes, input bit odd_tail, input bit with_bad,
                                  input bit with_read, input bit with_ignored);
      int n_chars;
      int bad_at;
      int mid_at;
      int k;
      n_chars = 2 * n_bytes + int'(odd_tail);
      bad_at  = with_bad ? $urandom_range(0, n_chars) : -1;
      mid_at  = $urandom_range(0, n_chars);
      for (k = 0; k <= n_chars; k++) begin
         if (with_read && k == mid_at)
            send_item(OP_READ, 8'($urandom_range(0, 255)));
         if (with_ignored && k == mid_at)
            send_item(OP_IGNORED, 8'($urandom_range(0, 255)));
         if (k == bad_at)
            send_item(OP_CHAR, pick_non_digit());
         if (k < n_chars)
            send_item(OP_CHAR, pick_digit());
      end
      send_item(OP_EOL, 8'($urandom_range(0, 255)));
   endtask

   // read straight after reset finds no card
   task automatic test_no_card_after_reset();
      send_item(OP_READ, 8'hFF);
      settle();
   endtask

   // short identifier with both digit bounds, an ignored opcode, read twice
   task automatic test_short_line_and_read();
      int digits [8] = '{0, 9, 9, 0, 1, 2, 3, 4};
      int k;
      for (k = 0; k < 8; k++) send_item(OP_CHAR, CHAR_ZERO + 8'(digits[k]));
      send_item(OP_EOL, 8'h00);
      send_item(OP_IGNORED, 8'hFF);
      send_item(OP_READ, 8'h00);
      send_item(OP_READ, 8'hFF);
      settle();
   endtask

   // lines refused for a non-digit or an odd digit count
   task automatic test_rejected_lines();
      send_item(OP_CHAR, CHAR_NINE + 8'd1);
      send_item(OP_EOL, 8'hFF);
      send_item(OP_CHAR, CHAR_ZERO + 8'd1);
      send_item(OP_EOL, 8'h00);
      send_item(OP_CHAR, 8'hFF);
      send_item(OP_EOL, 8'h00);
      settle();
   endtask

   // a read in the middle of a line keeps the line going
   task automatic test_read_mid_line();
      send_item(OP_CHAR, CHAR_ZERO + 8'd1);
      send_item(OP_READ, 8'h5A);
      send_item(OP_CHAR, CHAR_ZERO + 8'd2);
      send_item(OP_EOL, 8'hA5);
      settle();
   endtask

   // receiver holds off for a long stretch while full lines and reads keep coming
   task automatic test_backpressure();
      int k;
      idle_on      = 1'b0;
      hold_request = 1'b1;
      for (k = 0; k < 2; k++) begin
         send_digit_line(LEN_TRIPLE, 1'b0, 1'b0, 1'b0, 1'b0);
         send_item(OP_READ, 8'($urandom_range(0, 255)));
         send_item(OP_READ, 8'($urandom_range(0, 255)));
      end
      settle();
      idle_on = 1'b1;
   endtask

   // mostly well-formed lines with random digits, mixed with faults and noise
   task automatic test_random_traffic();
      int stop_at;
      int kind;
      int n;
      stop_at = items_sent + RANDOM_ITEMS;
      while (items_sent < stop_at) begin
         idle_on = ($urandom_range(0, 3) != 0);
         kind    = $urandom_range(0, 99);
         if (kind < 55) begin
            send_digit_line(pick_good_length(), 1'b0, 1'b0,
                            $urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0);
         end else if (kind < 65) begin
            send_digit_line($urandom_range(0, 10), 1'b1, 1'b0, 1'b0, 1'b0);
         end else if (kind < 75) begin
            send_digit_line(pick_good_length(), 1'b0, 1'b1, 1'b0, 1'b0);
         end else if (kind < 87) begin
            // wrong byte count, too long lines among them
            do n = $urandom_range(0, 12);
            while (n == LEN_SHORT || n == LEN_DOUBLE || n == LEN_TRIPLE);
            send_digit_line(n, 1'b0, 1'b0, 1'b0, 1'b0);
         end else begin
            repeat ($urandom_range(1, 4))
               send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
         end
         if ($urandom_range(0, 9) < 7)
            send_item(OP_READ, 8'($urandom_range(0, 255)));
      end
      settle();
      idle_on = 1'b1;
   endtask

   // result receiver with random stalls and an optional long hold-off
   initial begin
      int stall;
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_request = 1'b0;
         end
         stall = idle_on ? $urandom_range(0, 7) : 0;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned seen);
      if (want != seen) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, seen);
         error_count++;
      end
   endtask

   // compare each taken result item with the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_answers.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual tdata %0h tuser %0b",
                     $time, rsp_tdata, rsp_tuser);
            error_count++;
         end else begin
            want = pending_answers.pop_front();
            check_field("line_accepted", want.line_accepted, rsp_tdata[0]);
            check_field("uid_byte", want.uid_byte, rsp_tdata[8:1]);
            check_field("byte_index", want.byte_index, rsp_tdata[12:9]);
            check_field("uid_length", want.uid_length, rsp_tdata[16:13]);
            check_field("uid_ready", want.uid_ready, rsp_tdata[17]);
            check_field("status", want.status, rsp_tuser);
            check_field("last_of_run", want.last_of_run, rsp_tlast);
         end
      end
   end

   // watchdog on cycles with no item moving on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired with %0d results outstanding",
                  $time, pending_answers.size());
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // test sequence
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_no_card_after_reset();
      test_short_line_and_read();
      test_rejected_lines();
      test_read_mid_line();
      test_backpressure();
      test_random_traffic();
      repeat (DRAIN_CYCLES) @(posedge clock);
      while (pending_answers.size() != 0) @(posedge clock);
      $display("run covered %0d items: %0d lines committed, %0d lines rejected",
               items_sent, lines_committed, lines_rejected);
      $display("identifier bytes read: %0d, no-card reads: %0d, mismatches: %0d",
               id_bytes_read, no_card_reads, error_count);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
